// File: sv/vrf_pkg.sv
// Shared types, constants and arithmetic helpers for the vector refraction unit.
package vrf_pkg;

	localparam int COMP_W = 16;               // component width, Q4.12
	localparam int ETA_W = 16;                // index ratio width, Q2.14
	localparam int FRAC_BITS = 12;
	localparam int MAG_W = 31;                // normalized magnitude, MSB of largest at bit 30
	localparam int POS_W = $clog2(COMP_W);
	localparam int SHIFT_W = $clog2(MAG_W);
	localparam int JOB_DEPTH = 4;
	localparam int RESULT_DEPTH = 2;

	localparam logic signed [63:0] SAT_HI = 64'((64'sd1 <<< (COMP_W - 1)) - 64'sd1);
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	typedef struct packed {
		logic signed [COMP_W-1:0] incident_x;
		logic signed [COMP_W-1:0] incident_y;
		logic signed [COMP_W-1:0] incident_z;
		logic signed [COMP_W-1:0] normal_x;
		logic signed [COMP_W-1:0] normal_y;
		logic signed [COMP_W-1:0] normal_z;
		logic [ETA_W-1:0]         eta_ratio;
	} item_t;

	typedef struct packed {
		logic                     refracts;
		logic signed [COMP_W-1:0] refr_x;
		logic signed [COMP_W-1:0] refr_y;
		logic signed [COMP_W-1:0] refr_z;
	} result_t;

	// zero flag, signs, normal and ratio of one item, carried along the back end
	typedef struct packed {
		logic                   zero;
		logic [2:0]             neg;
		logic [2:0][COMP_W-1:0] nrm;
		logic [ETA_W-1:0]       eta;
	} dir_t;

	// classified item as queued between front and back
	typedef struct packed {
		dir_t                  dir;
		logic [2:0][MAG_W-1:0] mag;
	} job_t;

	// position of the highest set bit, zero for a zero word
	function automatic logic [POS_W-1:0] lead_pos(input logic [COMP_W-1:0] v);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < COMP_W; i++) begin
			if (v[i]) p = POS_W'(i);
		end
		return p;
	endfunction

	// right shift rounding to nearest, ties away from zero
	function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
			input int k);
		logic signed [63:0] half;
		half = 64'sd1 <<< (k - 1);
		if (v >= 0) return (v + half) >>> k;
		return -((-v + half) >>> k);
	endfunction

	function automatic logic signed [COMP_W-1:0] sat_comp(input logic signed [63:0] v);
		if (v > SAT_HI) return COMP_W'(SAT_HI);
		if (v < SAT_LO) return COMP_W'(SAT_LO);
		return COMP_W'(v);
	endfunction

endpackage

// File: sv/vrf_queue.sv
// Small first-word-fall-through queue on flip-flops.
module vrf_queue #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_pop)  rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= wdata;
	end

endmodule

// File: sv/vrf_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module vrf_isqrt #(
	parameter int W = 64,
	parameter int SB_W = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [W-1:0]    x,
	input  logic [SB_W-1:0] sb_in,
	output logic            out_valid,
	output logic [W/2-1:0]  root,
	output logic [SB_W-1:0] sb_out
);

	localparam int N = W / 2;

	logic [W-1:0]    rem_s [N];
	logic [W-1:0]    res_s [N];
	logic [SB_W-1:0] sb_s  [N];
	logic            v_s   [N];

	for (genvar g = 0; g < N; g++) begin : g_stage
		localparam logic [W-1:0] BITV = W'(1) << (W - 2 - 2 * g);
		logic [W-1:0]    rem_i, res_i, trial, rem_n, res_n;
		logic [SB_W-1:0] sb_i;
		logic            v_i;

		if (g == 0) begin : g_first
			assign rem_i = x;
			assign res_i = '0;
			assign sb_i  = sb_in;
			assign v_i   = in_valid;
		end else begin : g_next
			assign rem_i = rem_s[g-1];
			assign res_i = res_s[g-1];
			assign sb_i  = sb_s[g-1];
			assign v_i   = v_s[g-1];
		end

		// one trial subtraction
		always_comb begin
			trial = res_i + BITV;
			if (rem_i >= trial) begin
				rem_n = rem_i - trial;
				res_n = (res_i >> 1) + BITV;
			end else begin
				rem_n = rem_i;
				res_n = res_i >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[g] <= 1'b0;
			else if (en) v_s[g] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_n;
				res_s[g] <= res_n;
				sb_s[g]  <= sb_i;
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign root      = res_s[N-1][N-1:0];
	assign sb_out    = sb_s[N-1];

endmodule

// File: sv/vrf_div.sv
// Pipelined restoring divider, several lanes over one shared divisor, one quotient bit per stage.
module vrf_div #(
	parameter int LANES = 3,
	parameter int DEN_W = 32,
	parameter int Q_W = 13,
	parameter int SB_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [LANES-1:0][DEN_W+Q_W-1:0]   num,
	input  logic [DEN_W-1:0]                  den,
	input  logic [SB_W-1:0]                   sb_in,
	output logic                              out_valid,
	output logic [LANES-1:0][Q_W-1:0]         quo,
	output logic [SB_W-1:0]                   sb_out
);

	localparam int NUM_W = DEN_W + Q_W;

	logic [LANES-1:0][NUM_W-1:0] rem_s [Q_W];
	logic [LANES-1:0][Q_W-1:0]   q_s   [Q_W];
	logic [DEN_W-1:0]            den_s [Q_W];
	logic [SB_W-1:0]             sb_s  [Q_W];
	logic                        v_s   [Q_W];

	for (genvar g = 0; g < Q_W; g++) begin : g_stage
		localparam int J = Q_W - 1 - g;
		logic [LANES-1:0][NUM_W-1:0] rem_i, rem_n;
		logic [LANES-1:0][Q_W-1:0]   q_i, q_n;
		logic [DEN_W-1:0]            den_i;
		logic [NUM_W-1:0]            dsh;
		logic [SB_W-1:0]             sb_i;
		logic                        v_i;

		if (g == 0) begin : g_first
			assign rem_i = num;
			assign q_i   = '0;
			assign den_i = den;
			assign sb_i  = sb_in;
			assign v_i   = in_valid;
		end else begin : g_next
			assign rem_i = rem_s[g-1];
			assign q_i   = q_s[g-1];
			assign den_i = den_s[g-1];
			assign sb_i  = sb_s[g-1];
			assign v_i   = v_s[g-1];
		end

		// compare and subtract in each lane
		always_comb begin
			dsh   = NUM_W'(den_i) << J;
			rem_n = rem_i;
			q_n   = q_i;
			for (int l = 0; l < LANES; l++) begin
				if (rem_i[l] >= dsh) begin
					rem_n[l] = rem_i[l] - dsh;
					q_n[l][J] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[g] <= 1'b0;
			else if (en) v_s[g] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_n;
				q_s[g]   <= q_n;
				den_s[g] <= den_i;
				sb_s[g]  <= sb_i;
			end
		end
	end

	assign out_valid = v_s[Q_W-1];
	assign quo       = q_s[Q_W-1];
	assign sb_out    = sb_s[Q_W-1];

endmodule

// File: sv/vrf_front.sv
// Front end: takes items, finds magnitudes and the common normalizing shift, queues jobs.
module vrf_front #(
	parameter int DEPTH = vrf_pkg::JOB_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  vrf_pkg::item_t item,
	input  logic           job_pop,
	output logic           job_empty,
	output vrf_pkg::job_t  job
);

	import vrf_pkg::*;

	logic [2:0][COMP_W-1:0] inc, mag;
	logic [COMP_W-1:0]      mag_max;
	logic [SHIFT_W-1:0]     shift;
	job_t                   job_w;

	// classify: absolute values, zero check, shift that puts the largest at bit 30
	always_comb begin
		inc = {item.incident_z, item.incident_y, item.incident_x};
		for (int i = 0; i < 3; i++) begin
			mag[i] = inc[i][COMP_W-1] ? COMP_W'(~inc[i] + 1'b1) : inc[i];
		end
		mag_max = (mag[0] > mag[1]) ? mag[0] : mag[1];
		if (mag[2] > mag_max) mag_max = mag[2];
		shift = SHIFT_W'(MAG_W - 1) - SHIFT_W'(lead_pos(mag_max));

		job_w.dir.zero = (mag_max == '0);
		for (int i = 0; i < 3; i++) begin
			job_w.dir.neg[i] = inc[i][COMP_W-1];
			job_w.mag[i]     = MAG_W'(mag[i]) << shift;
		end
		job_w.dir.nrm = {item.normal_z, item.normal_y, item.normal_x};
		job_w.dir.eta = item.eta_ratio;
	end

	vrf_queue #(
		.W     ($bits(job_t)),
		.DEPTH (DEPTH)
	) u_job_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (job_w),
		.full  (full),
		.pop   (job_pop),
		.rdata (job),
		.empty (job_empty)
	);

endmodule

// File: sv/vrf_back.sv
// Back end: length, normalize, dot, discriminant, root and refracted vector, then result queue.
module vrf_back #(
	parameter int DEPTH = vrf_pkg::RESULT_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_empty,
	output logic             job_pop,
	input  vrf_pkg::job_t    job,
	output logic             empty,
	input  logic             pop,
	output vrf_pkg::result_t result
);

	import vrf_pkg::*;

	localparam int SQ_W  = 2 * MAG_W;
	localparam int LEN_W = 32;
	localparam int Q_W   = FRAC_BITS + 1;
	localparam int NUM_W = LEN_W + Q_W;
	localparam int UV_W  = Q_W + 1;
	localparam int P_W   = UV_W + COMP_W;
	localparam int PR_W  = 2 * COMP_W;
	localparam int E2_W  = 2 * ETA_W;
	localparam int C_W   = 2 * COMP_W + 1;
	localparam int D_W   = 2 * COMP_W + 2;
	localparam int DE_W  = D_W + ETA_W + 1;
	localparam int T_W   = DE_W - 2;
	localparam int RT_W  = LEN_W - 1;
	localparam int NR_W  = COMP_W + RT_W + 1;

	localparam logic signed [C_W-1:0] ONE_SQ   = C_W'(1) << (2 * FRAC_BITS);
	localparam logic signed [63:0]    DISC_ONE = 64'sd1 <<< 52;

	typedef struct packed {
		logic                   ok;
		logic [2:0][T_W-1:0]    t;
		logic [2:0][COMP_W-1:0] nrm;
	} tail_t;

	logic adv, res_full, res_push;

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic                  v_s10, v_s11, v_len, v_quo, v_isq;

	logic [2:0][SQ_W-1:0]  sq_s1;
	job_t                  job_s1, job_s2, job_len;
	logic [63:0]           ssum_s2;
	logic [LEN_W-1:0]      len;
	logic [2:0][NUM_W-1:0] num_s3;
	logic [LEN_W-1:0]      len_s3;
	dir_t                  dir_s3, dir_quo, dir_s4, dir_s5, dir_s6, dir_s7, dir_s8;
	logic [2:0][Q_W-1:0]   quo;

	logic signed [UV_W-1:0]  uv_c [3];
	logic signed [UV_W-1:0]  uv_s4 [3], uv_s5 [3], uv_s6 [3];
	logic signed [P_W-1:0]   p_s4 [3];
	logic signed [COMP_W-1:0] dt_s5;
	logic signed [PR_W-1:0]  dtsq_s6;
	logic [E2_W-1:0]         eta2_s6, eta2_s7;
	logic signed [PR_W-1:0]  nd_s6 [3];
	logic signed [C_W-1:0]   c_s7;
	logic signed [D_W-1:0]   d_s7 [3];
	logic signed [63:0]      prod_s8;
	logic signed [DE_W-1:0]  de_s8 [3];
	logic signed [63:0]      disc_c;
	logic [63:0]             rad_s9;
	tail_t                   tl_s9, tl_isq, tl_s10, tl_s11;
	logic [LEN_W-1:0]        isq;
	logic [RT_W-1:0]         root_s10;
	logic signed [NR_W-1:0]  nr_s11 [3];
	logic signed [COMP_W-1:0] r_c [3];
	result_t                 res_w;

	// whole back end moves together while the result queue has room
	assign adv      = !res_full;
	assign job_pop  = adv && !job_empty;
	assign res_push = adv && v_s11;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s1  <= !job_empty;
			v_s2  <= v_s1;
			v_s3  <= v_len;
			v_s4  <= v_quo;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_isq;
			v_s11 <= v_s10;
		end
	end

	// squares, then their sum
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= SQ_W'(job.mag[i]) * SQ_W'(job.mag[i]);
			end
			job_s1  <= job;
			ssum_s2 <= 64'(sq_s1[0]) + 64'(sq_s1[1]) + 64'(sq_s1[2]);
			job_s2  <= job_s1;
		end
	end

	// vector length
	vrf_isqrt #(
		.W    (64),
		.SB_W ($bits(job_t))
	) u_len_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s2),
		.x        (ssum_s2),
		.sb_in    (job_s2),
		.out_valid(v_len),
		.root     (len),
		.sb_out   (job_len)
	);

	// dividends for the unit vector, rounded to nearest
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				num_s3[i] <= (NUM_W'(job_len.mag[i]) << FRAC_BITS) + NUM_W'(len >> 1);
			end
			len_s3 <= len;
			dir_s3 <= job_len.dir;
		end
	end

	vrf_div #(
		.LANES (3),
		.DEN_W (LEN_W),
		.Q_W   (Q_W),
		.SB_W  ($bits(dir_t))
	) u_unit_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.num      (num_s3),
		.den      (len_s3),
		.sb_in    (dir_s3),
		.out_valid(v_quo),
		.quo      (quo),
		.sb_out   (dir_quo)
	);

	// signed unit components
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			uv_c[i] = dir_quo.neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
		end
	end

	// dot product, discriminant terms, tangent part
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				uv_s4[i] <= uv_c[i];
				p_s4[i]  <= P_W'(uv_c[i]) * P_W'($signed(dir_quo.nrm[i]));
			end
			dir_s4 <= dir_quo;

			dt_s5  <= sat_comp(round_shift(64'(p_s4[0]) + 64'(p_s4[1]) + 64'(p_s4[2]),
				FRAC_BITS));
			uv_s5  <= uv_s4;
			dir_s5 <= dir_s4;

			dtsq_s6 <= PR_W'(dt_s5) * PR_W'(dt_s5);
			eta2_s6 <= E2_W'(dir_s5.eta) * E2_W'(dir_s5.eta);
			for (int i = 0; i < 3; i++) begin
				nd_s6[i] <= PR_W'($signed(dir_s5.nrm[i])) * PR_W'(dt_s5);
			end
			uv_s6  <= uv_s5;
			dir_s6 <= dir_s5;

			c_s7 <= ONE_SQ - C_W'(dtsq_s6);
			for (int i = 0; i < 3; i++) begin
				d_s7[i] <= (D_W'(uv_s6[i]) <<< FRAC_BITS) - D_W'(nd_s6[i]);
			end
			eta2_s7 <= eta2_s6;
			dir_s7  <= dir_s6;

			prod_s8 <= 64'($signed({1'b0, eta2_s7})) * 64'(c_s7);
			for (int i = 0; i < 3; i++) begin
				de_s8[i] <= DE_W'(d_s7[i]) * DE_W'($signed({1'b0, dir_s7.eta}));
			end
			dir_s8 <= dir_s7;
		end
	end

	assign disc_c = DISC_ONE - prod_s8;

	// discriminant test; no refraction feeds zero to the root
	always_ff @(posedge clk) begin
		if (adv) begin
			tl_s9.ok <= (disc_c > 0) && !dir_s8.zero;
			rad_s9   <= ((disc_c > 0) && !dir_s8.zero) ? disc_c : '0;
			for (int i = 0; i < 3; i++) begin
				tl_s9.t[i] <= T_W'(round_shift(64'(de_s8[i]), 2));
			end
			tl_s9.nrm <= dir_s8.nrm;
		end
	end

	vrf_isqrt #(
		.W    (64),
		.SB_W ($bits(tail_t))
	) u_disc_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s9),
		.x        (rad_s9),
		.sb_in    (tl_s9),
		.out_valid(v_isq),
		.root     (isq),
		.sb_out   (tl_isq)
	);

	// normal term
	always_ff @(posedge clk) begin
		if (adv) begin
			root_s10 <= RT_W'((33'(isq) + 33'd2) >> 2);
			tl_s10   <= tl_isq;
			for (int i = 0; i < 3; i++) begin
				nr_s11[i] <= NR_W'($signed(tl_s10.nrm[i])) * NR_W'($signed({1'b0, root_s10}));
			end
			tl_s11 <= tl_s10;
		end
	end

	// final rounding and saturation
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_c[i] = tl_s11.ok ?
				sat_comp(round_shift(64'($signed(tl_s11.t[i])) - 64'(nr_s11[i]),
					2 * FRAC_BITS)) : '0;
		end
		res_w.refracts = tl_s11.ok;
		res_w.refr_x   = r_c[0];
		res_w.refr_y   = r_c[1];
		res_w.refr_z   = r_c[2];
	end

	vrf_queue #(
		.W     ($bits(result_t)),
		.DEPTH (DEPTH)
	) u_result_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_w),
		.full  (res_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule

// File: sv/vector_refraction_unit.sv
// Top level of the vector refraction unit: front end, job queue, back end.
//
//  channel  | handshake        | beat
//  ---------+------------------+---------------------------------------------
//  item     | push / full      | incident vector, unit normal, index ratio
//  result   | empty / pop      | refracts flag and refracted vector
//
// One item per cycle sustained while the result queue has room. Without stalls the
// result latency is set mostly by the two 32-stage square root pipelines and the
// 13-stage divider.
// Asynchronous reset empties both queues and all stage valids; no clearing pass.
// A stalled result holds the back end; the front keeps taking beats until the
// job queue fills.
module vector_refraction_unit #(
	parameter int JOB_DEPTH = vrf_pkg::JOB_DEPTH,
	parameter int RESULT_DEPTH = vrf_pkg::RESULT_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  vrf_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output vrf_pkg::result_t result
);

	import vrf_pkg::*;

	logic job_pop, job_empty;
	job_t job;

	vrf_front #(
		.DEPTH (JOB_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.job_pop  (job_pop),
		.job_empty(job_empty),
		.job      (job)
	);

	vrf_back #(
		.DEPTH (RESULT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.job      (job),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	// an accepted beat is in the job queue on the next cycle
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> !job_empty)
		else $error("accepted beat missing from job queue");

	// full front means queued work exists
	a_full_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !job_empty)
		else $error("front full with empty job queue");

	// a non-refracting result carries a zero vector
	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.refracts |->
		result.refr_x == '0 && result.refr_y == '0 && result.refr_z == '0)
		else $error("non-refracting result with nonzero vector");

endmodule
